// ===== hdl/qecq_pkg.sv =====
// types and constants shared by the quadrature encoder coalescing queue
// no dependencies
package qecq_pkg;

  localparam int DEF_NUM_ENCODERS = 4;
  localparam int DEF_QUEUE_DEPTH  = 16;

  localparam logic [31:0] DEF_SEND_INTERVAL = 32'd10000;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // sums that leave -127..126 after one step
  localparam logic signed [7:0] AMOUNT_OVER_HIGH = 8'sd127;
  localparam logic signed [7:0] AMOUNT_OVER_LOW  = -8'sd128;

  typedef struct packed {
    logic        cmd;
    logic [1:0]  encoder;
    logic        pin_a;
    logic        pin_b;
    logic [15:0] elapsed_us;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         enc_index;
    logic signed [7:0]  amount;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]         enc;
    logic signed [7:0]  amount;
  } entry_t;

endpackage

// ===== hdl/qecq_alu.sv =====
// shared 32-bit adder with carry in and carry out
// used for timer accumulate, interval compare and amount merge; no dependencies
module qecq_alu (
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic        cin,
  output logic [32:0] sum
);

  assign sum = {1'b0, a} + {1'b0, b} + {32'd0, cin};

endmodule

// ===== hdl/quadrature_encoder_coalescing_queue_core.sv =====
// quadrature encoder x2 decode with a coalescing movement queue
// depends on qecq_pkg and qecq_alu
// sample SAMPLE, MERGE on a step; tick TICK_ADD, TICK_CMP; entry FLUSH_READ/LOAD/SEND
// throughput: one item at a time; the shared adder and one memory read port set it
// a flush entry waits in the output register until its transfer
// reset: synchronous; clears levels, queue count, timer and sets the interval to 10000
module quadrature_encoder_coalescing_queue_core #(
  parameter int NUM_ENCODERS = qecq_pkg::DEF_NUM_ENCODERS,
  parameter int QUEUE_DEPTH  = qecq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  qecq_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output qecq_pkg::out_item_t result,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_data
);
  import qecq_pkg::*;

  localparam int ADDR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    IDLE, SAMPLE, MERGE, TICK_ADD, TICK_CMP, FLUSH_READ, FLUSH_LOAD, FLUSH_SEND
  } state_t;

  state_t                  state;
  in_item_t                item_q;
  logic [31:0]             send_interval;
  logic [31:0]             timer;
  logic [CNT_W-1:0]        count;
  logic [ADDR_W-1:0]       rd_idx;
  logic [NUM_ENCODERS-1:0] level_a;
  logic [NUM_ENCODERS-1:0] level_known;
  logic                    step_up;

  entry_t                  mem [QUEUE_DEPTH];
  entry_t                  rd_data;
  logic [ADDR_W-1:0]       rd_addr;
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_waddr;
  entry_t                  mem_wdata;

  logic [31:0]             alu_a;
  logic [31:0]             alu_b;
  logic                    alu_cin;
  logic [32:0]             alu_sum;

  logic                    cur_level;
  logic                    cur_known;
  logic                    enc_ok;
  logic                    step_needed;
  logic [ADDR_W-1:0]       tail_addr;
  logic signed [7:0]       total;
  logic                    tail_hit;
  logic                    total_zero;
  logic                    total_over;
  logic                    queue_full;
  logic                    do_push;

  qecq_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .cin (alu_cin),
    .sum (alu_sum)
  );

  assign item_ready = (state == IDLE);
  assign tail_addr  = ADDR_W'(count - 1'b1);
  assign queue_full = (count == CNT_W'(QUEUE_DEPTH));
  assign enc_ok     = int'(item_q.encoder) < NUM_ENCODERS;

  always_comb begin
    cur_level = 1'b0;
    cur_known = 1'b0;
    for (int i = 0; i < NUM_ENCODERS; i++) begin
      if (int'(item_q.encoder) == i) begin
        cur_level = level_a[i];
        cur_known = level_known[i];
      end
    end
  end

  assign step_needed = enc_ok && cur_known && (item_q.pin_a != cur_level);

  always_comb begin
    unique case (state)
      TICK_ADD: begin
        alu_a   = timer;
        alu_b   = {16'd0, item_q.elapsed_us};
        alu_cin = 1'b0;
      end
      TICK_CMP: begin
        alu_a   = timer;
        alu_b   = ~send_interval;
        alu_cin = 1'b1;
      end
      default: begin
        alu_a   = {{24{rd_data.amount[7]}}, rd_data.amount};
        alu_b   = step_up ? 32'd1 : 32'hFFFF_FFFF;
        alu_cin = 1'b0;
      end
    endcase
  end

  assign total      = alu_sum[7:0];
  assign tail_hit   = (count != '0) && (rd_data.enc == item_q.encoder);
  assign total_zero = (total == 8'sd0);
  assign total_over = (total == AMOUNT_OVER_HIGH) || (total == AMOUNT_OVER_LOW);
  assign do_push    = (!tail_hit || total_over) && !queue_full;

  always_comb begin
    rd_addr   = (state == SAMPLE) ? tail_addr : rd_idx;
    mem_we    = 1'b0;
    mem_waddr = tail_addr;
    mem_wdata = '{enc: item_q.encoder, amount: total};
    if (state == MERGE) begin
      if (tail_hit && !total_zero && !total_over) begin
        mem_we = 1'b1;
      end else if (do_push) begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(count);
        mem_wdata = '{enc: item_q.encoder, amount: step_up ? 8'sd1 : -8'sd1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      send_interval <= DEF_SEND_INTERVAL;
      timer         <= '0;
      count         <= '0;
      rd_idx        <= '0;
      level_a       <= '0;
      level_known   <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        send_interval <= cfg_data;
      end
      unique case (state)
        IDLE: begin
          if (item_valid) begin
            item_q <= item;
            state  <= (item.cmd == CMD_TICK) ? TICK_ADD : SAMPLE;
          end
        end
        SAMPLE: begin
          step_up <= (item_q.pin_b != item_q.pin_a);
          for (int i = 0; i < NUM_ENCODERS; i++) begin
            if (int'(item_q.encoder) == i) begin
              level_a[i]     <= item_q.pin_a;
              level_known[i] <= 1'b1;
            end
          end
          state <= step_needed ? MERGE : IDLE;
        end
        MERGE: begin
          if (tail_hit && total_zero) begin
            count <= count - 1'b1;
          end else if (do_push) begin
            count <= count + 1'b1;
          end
          state <= IDLE;
        end
        TICK_ADD: begin
          // saturate on carry out
          timer <= alu_sum[32] ? 32'hFFFF_FFFF : alu_sum[31:0];
          state <= TICK_CMP;
        end
        TICK_CMP: begin
          if (alu_sum[32]) begin
            timer  <= '0;
            rd_idx <= '0;
            state  <= (count == '0) ? IDLE : FLUSH_READ;
          end else begin
            state <= IDLE;
          end
        end
        FLUSH_READ: begin
          state <= FLUSH_LOAD;
        end
        FLUSH_LOAD: begin
          result.enc_index <= rd_data.enc;
          result.amount    <= rd_data.amount;
          result.last      <= (CNT_W'(rd_idx) + 1'b1 == count);
          result_valid     <= 1'b1;
          state            <= FLUSH_SEND;
        end
        FLUSH_SEND: begin
          if (result_ready) begin
            result_valid <= 1'b0;
            if (result.last) begin
              count <= '0;
              state <= IDLE;
            end else begin
              rd_idx <= rd_idx + 1'b1;
              state  <= FLUSH_READ;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/qecq_checker.sv =====
// port-level checks for the quadrature encoder coalescing queue
// depends on qecq_pkg; bound to quadrature_encoder_coalescing_queue_core
module qecq_checker (
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_ready,
  input logic                result_valid,
  input logic                result_ready,
  input qecq_pkg::out_item_t result
);
  import qecq_pkg::*;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("ready right after an input transfer");

  a_no_input_in_flush: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !item_ready)
    else $error("input open during flush");

  a_amount_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.amount != 8'sd0) && (result.amount != AMOUNT_OVER_LOW)
                     && (result.amount != AMOUNT_OVER_HIGH))
    else $error("flushed amount out of range");

endmodule

bind quadrature_encoder_coalescing_queue_core qecq_checker u_qecq_checker (.*);

// ===== sim/quadrature_encoder_coalescing_queue_core_tb.sv =====
// self-checking testbench for quadrature_encoder_coalescing_queue_core
// holds its own decode and coalescing predictor; depends on qecq_pkg and the core rtl
`timescale 1ns / 1ps

module quadrature_encoder_coalescing_queue_core_tb;
  import qecq_pkg::*;

  localparam int NUM_ENC       = DEF_NUM_ENCODERS;
  localparam int QDEPTH        = DEF_QUEUE_DEPTH;
  localparam int STEP_SUM_MAX  = 126;
  localparam int STEP_SUM_MIN  = -127;
  localparam bit DIR_UP        = 1'b1;
  localparam bit DIR_DOWN      = 1'b0;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD     = 300;
  localparam int QUIET_LIMIT   = 4000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  in_item_t    item = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  out_item_t   result;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;

  quadrature_encoder_coalescing_queue_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  // predictor state
  logic [31:0] send_interval = DEF_SEND_INTERVAL;
  logic [31:0] flush_timer   = '0;
  bit          pin_level [NUM_ENC];
  bit          level_seen [NUM_ENC];
  logic [1:0]  move_enc [QDEPTH];
  int          move_amt [QDEPTH];
  int          move_count = 0;
  out_item_t   flush_expect [$];

  // stimulus state
  in_item_t    item_backlog [$];
  bit          stim_a [NUM_ENC];
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  bit          hold_taken = 1'b0;
  int          send_gap = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  int          mismatch_count = 0;

  function automatic void coalesce_step(input logic [1:0] enc, input int step);
    int total;
    if (move_count > 0 && move_enc[move_count-1] == enc) begin
      total = move_amt[move_count-1] + step;
      if (total == 0) begin
        move_count--;
        return;
      end
      if (total >= STEP_SUM_MIN && total <= STEP_SUM_MAX) begin
        move_amt[move_count-1] = total;
        return;
      end
    end
    if (move_count < QDEPTH) begin
      move_enc[move_count] = enc;
      move_amt[move_count] = step;
      move_count++;
    end
  endfunction

  function automatic void decode_and_coalesce(input in_item_t it);
    logic [31:0] dt;
    out_item_t   r;
    dt = {16'b0, it.elapsed_us};
    if (it.cmd == CMD_SAMPLE) begin
      if (it.encoder < NUM_ENC) begin
        if (level_seen[it.encoder] && it.pin_a != pin_level[it.encoder])
          coalesce_step(it.encoder, (it.pin_b != it.pin_a) ? 1 : -1);
        pin_level[it.encoder]  = it.pin_a;
        level_seen[it.encoder] = 1'b1;
      end
    end else begin
      if (flush_timer > 32'hFFFF_FFFF - dt) flush_timer = 32'hFFFF_FFFF;
      else flush_timer = flush_timer + dt;
      if (flush_timer >= send_interval) begin
        flush_timer = '0;
        for (int i = 0; i < move_count; i++) begin
          r.enc_index = move_enc[i];
          r.amount    = move_amt[i][7:0];
          r.last      = (i == move_count - 1);
          flush_expect.insert(flush_expect.size(), r);
        end
        move_count = 0;
      end
    end
  endfunction

  task automatic push_item(input logic cmd, input logic [1:0] enc, input logic a,
                           input logic b, input logic [15:0] dt);
    in_item_t it;
    it.cmd        = cmd;
    it.encoder    = enc;
    it.pin_a      = a;
    it.pin_b      = b;
    it.elapsed_us = dt;
    item_backlog.insert(item_backlog.size(), it);
  endtask

  task automatic queue_sample(input logic [1:0] enc, input logic a, input logic b);
    push_item(CMD_SAMPLE, enc, a, b, 16'($urandom_range(0, 65535)));
    stim_a[enc] = a;
  endtask

  task automatic queue_tick(input int dt);
    push_item(CMD_TICK, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 16'(dt));
  endtask

  // well-formed rotation: each sample flips A, B chosen for the direction
  task automatic queue_turn(input logic [1:0] enc, input bit up, input int len);
    logic a;
    for (int i = 0; i < len; i++) begin
      a = ~stim_a[enc];
      queue_sample(enc, a, up ? ~a : a);
    end
  endtask

  task automatic wait_quiet();
    while (item_backlog.size() != 0 || item_valid || flush_expect.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic program_interval(input logic [31:0] v);
    wait_quiet();
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    send_interval = v;
    @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_ready) begin
      if (item_valid) decode_and_coalesce(item);
      if (send_gap > 0) begin
        send_gap   <= send_gap - 1;
        item_valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        send_gap   <= $urandom_range(0, 4);
        item_valid <= 1'b0;
      end else if (item_backlog.size() > 0) begin
        item       <= item_backlog[0];
        item_backlog.delete(0);
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // monitor and result-side stalls
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (flush_expect.size() == 0) begin
          $error("result transfer with nothing expected: enc_index %0d amount %0d last %0b",
                 result.enc_index, result.amount, result.last);
          mismatch_count++;
        end else begin
          if (result.enc_index !== flush_expect[0].enc_index) begin
            $error("enc_index: expected %0d, got %0d", flush_expect[0].enc_index,
                   result.enc_index);
            mismatch_count++;
          end
          if (result.amount !== flush_expect[0].amount) begin
            $error("amount: expected %0d, got %0d", flush_expect[0].amount, result.amount);
            mismatch_count++;
          end
          if (result.last !== flush_expect[0].last) begin
            $error("last: expected %0b, got %0b", flush_expect[0].last, result.last);
            mismatch_count++;
          end
          flush_expect.delete(0);
        end
      end
      if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        result_ready <= 1'b0;
      end else if (hold_req && !hold_taken) begin
        hold_taken   <= 1'b1;
        hold_left    <= LONG_HOLD - 1;
        result_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left   <= stall_left - 1;
        result_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left   <= $urandom_range(0, 4);
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int round;
    int pick;
    int tick_span;
    logic [31:0] interval;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // first samples only record levels
    queue_sample(0, 1'b1, 1'b0);
    queue_sample(1, 1'b0, 1'b1);
    queue_sample(2, 1'b1, 1'b1);
    queue_sample(3, 1'b0, 1'b0);
    // opposite steps cancel and drop the entry
    queue_turn(0, DIR_UP, 1);
    queue_turn(0, DIR_DOWN, 1);
    queue_sample(0, stim_a[0], ~stim_a[0]);
    queue_turn(1, DIR_UP, 2);
    queue_turn(2, DIR_DOWN, 1);
    queue_turn(3, DIR_UP, 1);
    queue_turn(1, DIR_DOWN, 1);
    queue_tick(0);
    queue_tick(65535);
    queue_tick(9999);
    queue_tick(1);

    // zero interval flushes on every tick, empty or not
    program_interval(32'd0);
    queue_turn(2, DIR_UP, 1);
    queue_tick(0);
    queue_tick(16'h5555);

    // fill the queue, then cancel at the tail while full and drop steps that find it full
    program_interval(32'd1);
    for (int i = 0; i < 18; i++) queue_turn(2'(i % 2), DIR_UP, 1);
    queue_turn(1, DIR_DOWN, 2);
    queue_turn(3, DIR_UP, 1);
    queue_turn(0, DIR_DOWN, 1);
    queue_tick(1);

    // largest interval: entries stay queued across ticks
    program_interval(32'hFFFF_FFFF);
    queue_turn(0, DIR_UP, 3);
    queue_tick(1);
    queue_tick(65535);

    program_interval(DEF_SEND_INTERVAL);
    queue_turn(3, DIR_DOWN, 2);
    queue_tick(10000);

    round = 0;
    while (round < 3) begin
      if (round == 1) begin
        interval  = $urandom;
        tick_span = 65535;
      end else begin
        interval  = $urandom_range(64, 4000);
        tick_span = interval;
      end
      program_interval(interval);
      if (round == 2) begin
        hold_req = 1'b1;
        queue_turn(0, DIR_UP, 3);
        queue_turn(1, DIR_DOWN, 2);
        queue_turn(2, DIR_UP, 1);
        queue_tick(tick_span);
      end
      for (int k = 0; k < 7; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 65)
          queue_turn(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                     $urandom_range(1, 4));
        else if (pick < 82)
          queue_tick($urandom_range(0, tick_span));
        else if (pick < 94)
          queue_sample(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
        else
          queue_tick($urandom_range(0, 65535));
      end
      round++;
    end

    // closing stretch with no random gaps or stalls on either side
    idle_on = 1'b0;
    program_interval(32'd500);
    for (int k = 0; k < 6; k++) begin
      if ($urandom_range(0, 3) == 0) queue_tick($urandom_range(0, 500));
      else queue_turn(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      $urandom_range(1, 3));
    end
    queue_tick(500);

    wait_quiet();
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/qecq_pkg.sv
hdl/qecq_alu.sv
hdl/quadrature_encoder_coalescing_queue_core.sv
hdl/qecq_checker.sv
sim/quadrature_encoder_coalescing_queue_core_tb.sv
